/* sv/mfpc_pkg.sv */
package mfpc_pkg;

   // field widths
   localparam int COST_W = 16;
   localparam int PATH_W = 32;
   localparam int CSR_W  = 9;

   // saturation ceiling of a path cost
   localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

   // reset value of the row width register
   localparam logic [CSR_W-1:0] ROW_WIDTH_RESET = CSR_W'(1);

   typedef logic [COST_W-1:0] cost_type;
   typedef logic [PATH_W-1:0] path_type;
   typedef logic [CSR_W-1:0]  csr_type;

   // neighbor selection for one cell
   typedef struct packed {
      logic first_row;
      logic has_left;
      logic has_right;
   } col_ctrl_type;

endpackage

/* sv/mfpc_req_if.sv */
interface mfpc_req_if import mfpc_pkg::*; ();
   logic     valid;
   logic     ready;
   cost_type cell_cost;
   logic     last_cell;

   modport source (output valid, output cell_cost, output last_cell, input ready);
   modport sink (input valid, input cell_cost, input last_cell, output ready);
endinterface

/* sv/mfpc_rsp_if.sv */
interface mfpc_rsp_if import mfpc_pkg::*; ();
   logic     valid;
   logic     ready;
   path_type path_cost;
   path_type best_total;
   logic     is_final;

   modport source (output valid, output path_cost, output best_total, output is_final,
                   input ready);
   modport sink (input valid, input path_cost, input best_total, input is_final,
                 output ready);
endinterface

/* sv/mfpc_line_store.sv */
module mfpc_line_store import mfpc_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  path_type      wr_data,
   output path_type      rd_data_a,
   output path_type      rd_data_b
);

   path_type mem [DEPTH];
   path_type rd_a_ff;
   path_type rd_b_ff;

   // previous row storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered reads, a same-cycle write to the same entry is seen
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* sv/mfpc_col_track.sv */
module mfpc_col_track import mfpc_pkg::*; #(
   parameter int MAX_COLUMNS = 256,
   parameter int AW          = 8,
   parameter int CW          = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_type       row_width,
   input  logic          advance,
   input  logic          last_cell,
   output logic [AW-1:0] col,
   output logic [AW-1:0] right_addr,
   output col_ctrl_type  ctrl
);

   logic [AW-1:0] col_ff;
   logic [AW-1:0] col_in;
   logic          first_ff;
   logic          first_in;
   logic [CW-1:0] width_eff;
   logic [CW-1:0] col_ext;
   logic [CW-1:0] j_ext;
   logic [CW-1:0] j_next;
   logic          has_right;

   // usable row width, clipped to 1..MAX_COLUMNS
   always_comb begin
      priority if (row_width == '0) begin
         width_eff = CW'(1);
      end else if (32'(row_width) > 32'(MAX_COLUMNS)) begin
         width_eff = CW'(MAX_COLUMNS);
      end else begin
         width_eff = CW'(row_width);
      end
   end

   // current column, pulled back to the row end if the width shrank
   assign col_ext   = CW'(col_ff);
   assign j_ext     = (col_ext >= width_eff) ? (width_eff - CW'(1)) : col_ext;
   assign j_next    = j_ext + CW'(1);
   assign has_right = ({1'b0, j_ext} + (CW+1)'(1)) < {1'b0, width_eff};

   assign col            = AW'(j_ext);
   assign right_addr     = has_right ? AW'(j_next) : AW'(j_ext);
   assign ctrl.first_row = first_ff;
   assign ctrl.has_left  = (j_ext != '0);
   assign ctrl.has_right = has_right;

   // next column and row phase
   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (advance) begin
         priority if (last_cell) begin
            col_in   = '0;
            first_in = 1'b1;
         end else if (!has_right) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in = AW'(j_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

endmodule

/* sv/mfpc_path_calc.sv */
module mfpc_path_calc import mfpc_pkg::*; (
   input  cost_type     cell_cost,
   input  logic         last_cell,
   input  col_ctrl_type ctrl,
   input  path_type     above,
   input  path_type     right_above,
   input  path_type     left_above,
   input  path_type     row_min,
   output path_type     path_cost,
   output path_type     best_total,
   output path_type     row_min_next
);

   path_type            min_lr;
   path_type            min_up;
   logic [PATH_W:0]     sum;

   // least of the neighbors above that exist
   always_comb begin
      min_lr = above;
      if (ctrl.has_left && (left_above < min_lr)) begin
         min_lr = left_above;
      end
      min_up = min_lr;
      if (ctrl.has_right && (right_above < min_lr)) begin
         min_up = right_above;
      end
   end

   // saturating add, first row passes the cost through
   assign sum = {1'b0, min_up} + (PATH_W+1)'(cell_cost);

   always_comb begin
      if (ctrl.first_row) begin
         path_cost = PATH_W'(cell_cost);
      end else if (sum[PATH_W]) begin
         path_cost = PATH_MAX;
      end else begin
         path_cost = sum[PATH_W-1:0];
      end
   end

   // running minimum of the current row
   assign row_min_next = (ctrl.has_left && (row_min < path_cost)) ? row_min : path_cost;
   assign best_total   = last_cell ? row_min_next : '0;

endmodule

/* sv/min_falling_path_cost_unit.sv */
// path: a cell goes from its request transfer into the cell stage register, then into the
// result register, from which its result transfer is made
// throughput: one cell per cycle, stalls only when the result register is held
// the line store reads two entries a cycle and writes one, so no port limits rate
// reset is synchronous, active high, and clears control state and the row width
// register to 1; the line store is not cleared and is rewritten by each first row
module min_falling_path_cost_unit import mfpc_pkg::*; #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic        clock,
   input  logic        reset,
   mfpc_req_if.sink    req_bus,
   mfpc_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  csr_type     csr_wdata
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   csr_type       csr_width_ff;

   logic          req_go;
   logic          cell_go;
   logic [AW-1:0] col;
   logic [AW-1:0] right_addr;
   col_ctrl_type  ctrl;

   // cell stage
   logic          cell_valid_ff;
   cost_type      cell_cost_ff;
   logic          cell_last_ff;
   logic [AW-1:0] cell_col_ff;
   col_ctrl_type  cell_ctrl_ff;

   path_type      above;
   path_type      right_above;
   path_type      left_ff;
   path_type      row_min_ff;
   path_type      row_min_in;
   path_type      path_cost;
   path_type      best_total;

   // result register
   logic          rsp_valid_ff;
   path_type      rsp_path_ff;
   path_type      rsp_best_ff;
   logic          rsp_final_ff;

   // row width register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_we) begin
         csr_width_ff <= csr_wdata;
      end
   end

   // handshakes
   assign cell_go       = cell_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !cell_valid_ff || cell_go;
   assign req_go        = req_bus.valid && req_bus.ready;

   mfpc_col_track #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .AW          (AW),
      .CW          (CW)
   ) u_col_track (
      .clock      (clock),
      .reset      (reset),
      .row_width  (csr_width_ff),
      .advance    (req_go),
      .last_cell  (req_bus.last_cell),
      .col        (col),
      .right_addr (right_addr),
      .ctrl       (ctrl)
   );

   mfpc_line_store #(
      .DEPTH (MAX_COLUMNS),
      .AW    (AW)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (req_go),
      .rd_addr_a (col),
      .rd_addr_b (right_addr),
      .wr_en     (cell_go),
      .wr_addr   (cell_col_ff),
      .wr_data   (path_cost),
      .rd_data_a (above),
      .rd_data_b (right_above)
   );

   // cell stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         cell_valid_ff <= req_bus.valid;
      end
   end

   // cell stage payload
   always_ff @(posedge clock) begin
      if (req_go) begin
         cell_cost_ff <= req_bus.cell_cost;
         cell_last_ff <= req_bus.last_cell;
         cell_col_ff  <= col;
         cell_ctrl_ff <= ctrl;
      end
   end

   mfpc_path_calc u_path_calc (
      .cell_cost    (cell_cost_ff),
      .last_cell    (cell_last_ff),
      .ctrl         (cell_ctrl_ff),
      .above        (above),
      .right_above  (right_above),
      .left_above   (left_ff),
      .row_min      (row_min_ff),
      .path_cost    (path_cost),
      .best_total   (best_total),
      .row_min_next (row_min_in)
   );

   // left neighbor and row minimum carry to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         row_min_ff <= PATH_MAX;
      end else if (cell_go) begin
         left_ff    <= cell_last_ff ? '0 : above;
         row_min_ff <= cell_last_ff ? PATH_MAX : row_min_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cell_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cell_go) begin
         rsp_path_ff  <= path_cost;
         rsp_best_ff  <= best_total;
         rsp_final_ff <= cell_last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.path_cost  = rsp_path_ff;
   assign rsp_bus.best_total = rsp_best_ff;
   assign rsp_bus.is_final   = rsp_final_ff;

`ifndef ASSERT_OFF
   // a cell leaving the cell stage always lands in the result register
   a_cell_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cell_go |=> rsp_bus.valid)
      else $error("cell transfer did not reach the result register");

   // a cell held by a stalled result register stays in the cell stage
   a_cell_hold: assert property (@(posedge clock) disable iff (reset)
      (cell_valid_ff && !cell_go) |=> (cell_valid_ff && $stable(cell_col_ff)))
      else $error("stalled cell left the cell stage");

   // the grid's last cell returns the column tracker to the first row
   a_grid_restart: assert property (@(posedge clock) disable iff (reset)
      (req_go && req_bus.last_cell) |=> (ctrl.first_row && (col == '0)))
      else $error("column tracker not restarted after the last cell");

   // the row minimum goes back to all ones after the grid's last cell
   a_row_min_reset: assert property (@(posedge clock) disable iff (reset)
      (cell_go && cell_last_ff) |=> (row_min_ff == PATH_MAX))
      else $error("row minimum not cleared after the last cell");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;
   import mfpc_pkg::*;

   localparam int          LINE_COLS   = 256;
   localparam int unsigned CYCLE_LIMIT = 50000;
   localparam int          PRINT_LIMIT = 40;

   typedef struct {
      path_type path_cost;
      path_type best_total;
      logic     is_final;
   } path_result_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_we;
   csr_type csr_wdata;

   mfpc_req_if req_bus();
   mfpc_rsp_if rsp_bus();

   min_falling_path_cost_unit #(.MAX_COLUMNS(LINE_COLS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's grid state
   path_type    prev_row_costs [LINE_COLS];
   path_type    left_prev;
   int unsigned next_col;
   logic        first_row_now;
   path_type    row_best;
   csr_type     width_reg;

   path_result_type path_costs_due[$];

   int          send_gap_pct;
   int          recv_stall_pct;
   logic        hold_on;
   int unsigned cycle_count;
   int unsigned cells_sent;
   int unsigned results_checked;
   int unsigned grids_done;
   int unsigned error_count;

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  path_costs_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input path_type got, input path_type want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch on %s at result %0d: got %h, expected %h", what, results_checked,
                  got, want);
   endtask

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_COLS) w = LINE_COLS;
      return w;
   endfunction

   function automatic void clear_grid();
      foreach (prev_row_costs[i]) prev_row_costs[i] = '0;
      left_prev     = '0;
      next_col      = 0;
      first_row_now = 1'b1;
      row_best      = PATH_MAX;
   endfunction

   // cost of the cheapest falling path into the next cell
   function automatic path_result_type predict_path_cost(input cost_type cost, input logic last);
      int unsigned     w;
      int unsigned     j;
      path_type        above;
      path_type        best;
      logic [PATH_W:0] sum;
      path_result_type r;
      w = eff_width();
      j = (next_col >= w) ? w - 1 : next_col;
      above = prev_row_costs[j];
      if (first_row_now) begin
         r.path_cost = path_type'(cost);
      end else begin
         best = above;
         if (j > 0 && left_prev < best) best = left_prev;
         if (j + 1 < w && prev_row_costs[j + 1] < best) best = prev_row_costs[j + 1];
         sum = {1'b0, best} + (PATH_W + 1)'(cost);
         r.path_cost = sum[PATH_W] ? PATH_MAX : sum[PATH_W-1:0];
      end
      left_prev = above;
      prev_row_costs[j] = r.path_cost;
      if (j == 0 || r.path_cost < row_best) row_best = r.path_cost;
      r.best_total = last ? row_best : '0;
      r.is_final   = last;
      // advance to the next cell or start over after the grid
      if (last) begin
         clear_grid();
      end else if (j + 1 >= w) begin
         next_col      = 0;
         first_row_now = 1'b0;
      end else begin
         next_col = j + 1;
      end
      return r;
   endfunction

   function automatic cost_type random_cost();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return '1;
         2, 3: return cost_type'($urandom_range(15, 0));
         default: return cost_type'($urandom);
      endcase
   endfunction

   // one cell transfer on the request channel
   task automatic send_cell(input cost_type cost, input logic last);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cell_cost <= cost;
      req_bus.last_cell <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      path_costs_due.insert(path_costs_due.size(), predict_path_cost(cost, last));
      cells_sent++;
   endtask

   // stop offering and let every pending result come back
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (path_costs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_row_width(input csr_type value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      width_reg = value;
   endtask

   task automatic set_idling(input int gap_pct, input int stall_pct);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
   endtask

   // one grid of random costs; may end early or narrow the rows partway through
   task automatic send_grid(input int unsigned rows, input int unsigned cut_at,
                            input int unsigned narrow_at, input csr_type narrow_to);
      int unsigned rows_left;
      int unsigned sent;
      logic        ends_row;
      logic        last;
      rows_left = rows;
      sent      = 0;
      forever begin
         ends_row = (next_col + 1 >= eff_width());
         last     = (ends_row && rows_left == 1) || (sent + 1 == cut_at);
         send_cell(random_cost(), last);
         sent++;
         if (last) break;
         if (ends_row) rows_left--;
         if (sent == narrow_at) begin
            wait_drain();
            write_row_width(narrow_to);
         end
      end
      grids_done++;
   endtask

   // result check against the oldest pending prediction
   task automatic check_result(input path_type cost, input path_type best, input logic fin);
      path_result_type want;
      if (path_costs_due.size() == 0) begin
         report_mismatch("unexpected result", cost, '0);
         return;
      end
      want = path_costs_due.pop_front();
      results_checked++;
      if (cost !== want.path_cost) report_mismatch("path_cost", cost, want.path_cost);
      if (best !== want.best_total) report_mismatch("best_total", best, want.best_total);
      if (fin !== want.is_final)
         report_mismatch("is_final", path_type'(fin), path_type'(want.is_final));
   endtask

   // result side: transfer check, then random stalls or a long hold
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_result(rsp_bus.path_cost, rsp_bus.best_total, rsp_bus.is_final);
      if (hold_on)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // width at reset, then width zero: every cell sees only the one above
   task automatic test_single_column();
      set_idling(0, 0);
      send_cell(16'h0000, 1'b0);
      send_cell(16'hFFFF, 1'b0);
      send_cell(16'h5555, 1'b0);
      send_cell(16'hAAAA, 1'b1);
      wait_drain();
      write_row_width(csr_type'(0));
      send_cell(16'd7, 1'b0);
      send_cell(16'd3, 1'b0);
      send_cell(16'd1, 1'b1);
      wait_drain();
   endtask

   // edge clipping on a narrow grid and a last cell before the row is done
   task automatic test_small_grids();
      write_row_width(csr_type'(3));
      send_cell(16'hFFFF, 1'b0);
      send_cell(16'h0000, 1'b0);
      send_cell(16'hFFFF, 1'b0);
      send_cell(16'h0000, 1'b0);
      send_cell(16'hFFFF, 1'b0);
      send_cell(16'h0000, 1'b0);
      send_cell(16'd1, 1'b0);
      send_cell(16'd2, 1'b0);
      send_cell(16'd3, 1'b1);
      wait_drain();
      write_row_width(csr_type'(4));
      send_cell(16'd9, 1'b0);
      send_cell(16'd4, 1'b0);
      send_cell(16'd7, 1'b0);
      send_cell(16'd1, 1'b0);
      send_cell(16'd5, 1'b0);
      send_cell(16'd8, 1'b1);
      wait_drain();
   endtask

   // row width lowered mid-row, later row and first row, and down to zero
   task automatic test_mid_row_narrowing();
      set_idling(30, 30);
      write_row_width(csr_type'(6));
      send_grid(3, 0, 10, csr_type'(2));
      wait_drain();
      write_row_width(csr_type'(5));
      send_grid(3, 0, 3, csr_type'(2));
      wait_drain();
      write_row_width(csr_type'(4));
      send_grid(3, 0, 6, csr_type'(0));
      wait_drain();
   endtask

   // long receiver hold while the sender keeps offering
   task automatic test_back_pressure();
      set_idling(0, 0);
      write_row_width(csr_type'(8));
      fork
         begin
            hold_on <= 1'b1;
            repeat (150) @(posedge clock);
            hold_on <= 1'b0;
         end
      join_none
      send_grid(6, 0, 0, '0);
      wait_drain();
   endtask

   // full line store width, and a width above it that saturates
   task automatic test_wide_rows();
      set_idling(30, 30);
      write_row_width(csr_type'(LINE_COLS));
      send_grid(2, 0, 0, '0);
      wait_drain();
      set_idling(0, 57);
      write_row_width('1);
      send_grid(2, LINE_COLS + 10, 0, '0);
      wait_drain();
   endtask

   // random grids across every idling phase
   task automatic test_random_grids();
      int unsigned target;
      int unsigned rows;
      int unsigned cols;
      int unsigned cut_at;
      int unsigned narrow_at;
      csr_type     width_pick;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(57, 0);
            2: set_idling(0, 57);
            default: set_idling(30, 30);
         endcase
         target = cells_sent + 130;
         while (cells_sent < target) begin
            case ($urandom_range(9, 0))
               0: width_pick = '0;
               1: width_pick = csr_type'($urandom_range(40, 13));
               default: width_pick = csr_type'($urandom_range(12, 1));
            endcase
            write_row_width(width_pick);
            cols      = eff_width();
            rows      = $urandom_range(6, 1);
            cut_at    = 0;
            narrow_at = 0;
            if ($urandom_range(5, 0) == 0 && rows * cols > 1)
               cut_at = $urandom_range(rows * cols - 1, 1);
            if ($urandom_range(5, 0) == 0 && rows > 1 && cols > 1)
               narrow_at = $urandom_range(rows * cols - 1, cols + 1);
            send_grid(rows, cut_at, narrow_at, csr_type'($urandom_range(cols - 1, 1)));
            wait_drain();
         end
      end
   endtask

   // a deep single column that builds up large path costs
   task automatic test_deep_column();
      set_idling(0, 0);
      write_row_width(csr_type'(1));
      repeat (96) send_cell(16'hFFFF, 1'b0);
      send_cell(16'h0000, 1'b0);
      send_cell(16'hFFFF, 1'b0);
      send_cell(16'h0001, 1'b1);
      wait_drain();
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.cell_cost = '0;
      req_bus.last_cell = 1'b0;
      rsp_bus.ready     = 1'b0;
      hold_on           = 1'b0;
      send_gap_pct      = 0;
      recv_stall_pct    = 0;
      cycle_count       = 0;
      cells_sent        = 0;
      results_checked   = 0;
      grids_done        = 0;
      error_count       = 0;
      clear_grid();
      width_reg = ROW_WIDTH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_single_column();
      test_small_grids();
      test_mid_row_narrowing();
      test_back_pressure();
      test_wide_rows();
      test_random_grids();
      test_deep_column();
      repeat (8) @(posedge clock);

      $display("%0d cells sent, %0d results checked, %0d generated grids, %0d mismatches",
               cells_sent, results_checked, grids_done, error_count);
      $display("row widths 0 to 511, narrowing mid-row, early last cells, stalls, deep column");
      if (error_count == 0 && path_costs_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
